// ===== rtl/core/smau_pkg.sv =====
// Package with shared types and constants of the small matrix arithmetic unit.
`timescale 1ns / 1ps
package smau_pkg;
    localparam int VALUE_WIDTH = 40;
    localparam int ADDR_WIDTH  = 6;

    typedef enum logic [2:0] {
        OP_MUL = 3'd0,
        OP_ADD = 3'd1,
        OP_SUB = 3'd2,
        OP_EQ  = 3'd3,
        OP_TRN = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        REG_OP_MODE = 3'd0,
        REG_ROWS_A  = 3'd1,
        REG_COLS_A  = 3'd2,
        REG_ROWS_B  = 3'd3,
        REG_COLS_B  = 3'd4
    } t_reg;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_MAC,
        ST_EMIT,
        ST_FLAG
    } t_state;
endpackage

// ===== rtl/core/smau_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module smau_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/small_matrix_arithmetic_unit_core.sv =====
// Top level of the small matrix arithmetic unit.
`timescale 1ns / 1ps
// Elements stream in one per cycle while the block is loading, A then B (B is
// not loaded in transpose mode), into two RAMs. After the last element the
// block walks the RAMs: each result element of an add, subtract or transpose
// goes through address, read and emit steps; each product element goes through
// one shared multiply-accumulate unit fed by the RAM read ports (cols_a reads,
// the read and product pipeline, scale, emit). Equality scans the elements when
// the dimensions match. No input is taken during computation.
module small_matrix_arithmetic_unit_core
    import smau_pkg::*;
#(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [3:0]            i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [ELEM_WIDTH-1:0] element
    input  logic [((ELEM_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [39:0] value
    output logic [VALUE_WIDTH-1:0] m_axis_tdata,
    // [0] equal_flag, [1] dim_error
    output logic [1:0]            m_axis_tuser,
    output logic                  m_axis_tlast
);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = 2 * ELEM_WIDTH;
    localparam int AccW  = PW + 4;
    localparam int SH    = 16 - FRAC_BITS;
    localparam logic signed [63:0] VMAX = 64'sd549755813887;
    localparam logic signed [63:0] VMIN = -64'sd549755813888;

    // Configuration registers
    logic [2:0] r_op;
    logic [3:0] r_ra, r_ca, r_rb, r_cb;
    logic [3:0] ra, ca, rb, cb;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= OP_MUL;
            r_ra <= 4'd1; r_ca <= 4'd1; r_rb <= 4'd1; r_cb <= 4'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_OP_MODE: r_op <= i_cfg_data[2:0];
                REG_ROWS_A:  r_ra <= i_cfg_data;
                REG_COLS_A:  r_ca <= i_cfg_data;
                REG_ROWS_B:  r_rb <= i_cfg_data;
                REG_COLS_B:  r_cb <= i_cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic [3:0] clampd(input logic [3:0] d);
        if (d == 4'd0) return 4'd1;
        if (d > 4'(MAX_DIM)) return 4'(MAX_DIM);
        return d;
    endfunction
    assign ra = clampd(r_ra);
    assign ca = clampd(r_ca);
    assign rb = clampd(r_rb);
    assign cb = clampd(r_cb);

    // Control state
    t_state r_st, n_st;
    logic [6:0] r_cnt, n_cnt;
    logic r_lb, n_lb;
    logic [3:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic r_eq, n_eq;
    logic signed [AccW-1:0] r_acc, n_acc;
    logic r_mac_v, n_mac_v;
    logic r_ov, n_ov;
    logic r_pv, n_pv;
    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic [1:0] r_usr, n_usr;
    logic r_last, n_last;
    logic r_rdv, n_rdv;

    logic [6:0] na, nb;
    logic [6:0] a_addr, b_addr;
    logic [AW-1:0] ra_addr, rb_addr;
    logic signed [ELEM_WIDTH-1:0] a_q, b_q;
    logic ld_fire;
    logic [ELEM_WIDTH-1:0] elem;

    assign elem  = s_axis_tdata[ELEM_WIDTH-1:0];
    assign na    = 7'(ra * ca);
    assign nb    = 7'(rb * cb);
    assign s_axis_tready = (r_st == ST_LOAD);
    assign ld_fire = s_axis_tvalid && s_axis_tready;

    smau_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_a (
        .i_clk(i_clk), .i_we(ld_fire && !r_lb && r_cnt < 7'(DEPTH)),
        .i_waddr(r_cnt[AW-1:0]), .i_wdata(elem), .i_raddr(ra_addr), .o_rdata(a_q));
    smau_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_b (
        .i_clk(i_clk), .i_we(ld_fire && r_lb && r_cnt < 7'(DEPTH)),
        .i_waddr(r_cnt[AW-1:0]), .i_wdata(elem), .i_raddr(rb_addr), .o_rdata(b_q));

    // Read addresses per mode
    always_comb begin
        unique case (r_op)
            OP_MUL: begin
                a_addr = 7'(r_i * ca + r_k);
                b_addr = 7'(r_k * cb + r_j);
            end
            OP_TRN: begin
                a_addr = 7'(r_j * ca + r_i);
                b_addr = 7'd0;
            end
            default: begin
                a_addr = r_cnt;
                b_addr = r_cnt;
            end
        endcase
    end
    assign ra_addr = a_addr[AW-1:0];
    assign rb_addr = b_addr[AW-1:0];

    // Registered product
    logic signed [PW-1:0] r_prod;
    always_ff @(posedge i_clk) begin
        r_prod <= a_q * b_q;
    end

    // Scale an element-width value to 16 fraction bits with saturation
    function automatic logic [VALUE_WIDTH-1:0] scale_e(input logic signed [ELEM_WIDTH+1:0] v);
        logic signed [63:0] x;
        x = 64'(v);
        if (SH >= 0) x = x <<< SH;
        else x = x >>> (-SH);
        if (x > VMAX) x = VMAX;
        if (x < VMIN) x = VMIN;
        return x[VALUE_WIDTH-1:0];
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] scale_p(input logic signed [AccW-1:0] v);
        logic signed [63:0] x;
        x = 64'(v);
        if (2*FRAC_BITS <= 16) x = x <<< (16 - 2*FRAC_BITS);
        else x = x >>> (2*FRAC_BITS - 16);
        if (x > VMAX) x = VMAX;
        if (x < VMIN) x = VMIN;
        return x[VALUE_WIDTH-1:0];
    endfunction

    // Sequencer
    always_comb begin
        logic signed [ELEM_WIDTH+1:0] s;
        n_st = r_st; n_cnt = r_cnt; n_lb = r_lb; n_i = r_i; n_j = r_j; n_k = r_k;
        n_eq = r_eq; n_acc = r_acc; n_mac_v = 1'b0; n_ov = r_ov; n_pv = 1'b0;
        n_val = r_val; n_usr = r_usr; n_last = r_last; n_rdv = 1'b0;
        s = '0;
        unique case (r_st)
            ST_LOAD: begin
                if (ld_fire) begin
                    n_cnt = r_cnt + 7'd1;
                    n_i = '0; n_j = '0; n_k = '0; n_eq = 1'b1;
                    n_acc = '0;
                    if (!r_lb && r_cnt + 7'd1 >= na) begin
                        n_cnt = '0;
                        if (r_op == OP_TRN) begin
                            n_st = ST_READ; n_rdv = 1'b1;
                        end else begin
                            n_lb = 1'b1;
                        end
                    end else if (r_lb && r_cnt + 7'd1 >= nb) begin
                        n_cnt = '0; n_lb = 1'b0;
                        n_eq = (ra == rb) && (ca == cb);
                        priority if (r_op == OP_MUL && ca == rb) begin
                            n_st = ST_MAC; n_mac_v = 1'b1;
                        end else if ((r_op == OP_ADD || r_op == OP_SUB)
                                     && ra == rb && ca == cb) begin
                            n_st = ST_READ; n_rdv = 1'b1;
                        end else if (r_op == OP_EQ) begin
                            n_st = ((ra == rb) && (ca == cb)) ? ST_READ : ST_FLAG;
                            n_rdv = 1'b1;
                        end else begin
                            n_val = '0; n_usr = 2'b10; n_last = 1'b1;
                            n_st = ST_EMIT;
                        end
                    end
                end
            end
            ST_READ: begin
                // RAM data for the current index is valid now
                unique case (r_op)
                    OP_TRN: begin
                        n_val = scale_e((ELEM_WIDTH+2)'(a_q));
                        n_usr = 2'b00;
                        n_last = (r_i + 4'd1 == ca) && (r_j + 4'd1 == ra);
                        n_st = ST_EMIT;
                    end
                    OP_ADD: begin
                        s = (ELEM_WIDTH+2)'(a_q) + (ELEM_WIDTH+2)'(b_q);
                        n_val = scale_e(s); n_usr = 2'b00;
                        n_last = (r_cnt + 7'd1 == na); n_st = ST_EMIT;
                    end
                    OP_SUB: begin
                        s = (ELEM_WIDTH+2)'(a_q) - (ELEM_WIDTH+2)'(b_q);
                        n_val = scale_e(s); n_usr = 2'b00;
                        n_last = (r_cnt + 7'd1 == na); n_st = ST_EMIT;
                    end
                    default: begin
                        if (r_rdv && r_eq) begin
                            // first cycle: data of entry r_cnt valid
                        end
                        if (a_q != b_q) n_eq = 1'b0;
                        if (r_cnt + 7'd1 >= na) begin
                            n_st = ST_FLAG;
                        end else begin
                            n_cnt = r_cnt + 7'd1;
                            n_st = ST_LOAD;
                            n_st = ST_READ;
                        end
                    end
                endcase
            end
            ST_MAC: begin
                // Issue reads for k, accumulate the product once it has passed the RAM read register and r_prod
                if (r_k + 4'd1 < ca) begin
                    n_k = r_k + 4'd1; n_mac_v = 1'b1;
                end
                if (r_pv) n_acc = r_acc + AccW'(r_prod);
                n_ov = r_mac_v;
                n_pv = r_ov;
                if (!r_mac_v && !r_ov && !r_pv && r_k + 4'd1 >= ca) begin
                    n_val = scale_p(r_acc); n_usr = 2'b00;
                    n_last = (r_i + 4'd1 == ra) && (r_j + 4'd1 == cb);
                    n_st = ST_EMIT;
                end
            end
            ST_FLAG: begin
                if (r_rdv) begin
                    n_st = ST_FLAG;
                end else begin
                    n_val = '0; n_usr = {1'b0, r_eq}; n_last = 1'b1; n_st = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (m_axis_tready) begin
                    if (r_last) begin
                        n_st = ST_LOAD; n_cnt = '0;
                    end else if (r_op == OP_MUL) begin
                        n_k = '0; n_acc = '0; n_st = ST_MAC; n_mac_v = 1'b1;
                        if (r_j + 4'd1 == cb) begin
                            n_j = '0; n_i = r_i + 4'd1;
                        end else begin
                            n_j = r_j + 4'd1;
                        end
                    end else if (r_op == OP_TRN) begin
                        n_st = ST_READ; n_rdv = 1'b1;
                        if (r_j + 4'd1 == ra) begin
                            n_j = '0; n_i = r_i + 4'd1;
                        end else begin
                            n_j = r_j + 4'd1;
                        end
                    end else begin
                        n_cnt = r_cnt + 7'd1; n_st = ST_READ; n_rdv = 1'b1;
                    end
                end
            end
            default: n_st = ST_LOAD;
        endcase
    end

    // Registers; a read state always waits, with r_wait set, after its address is set
    logic r_wait;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_LOAD; r_cnt <= '0; r_lb <= 1'b0; r_i <= '0; r_j <= '0;
            r_k <= '0; r_eq <= 1'b0; r_acc <= '0; r_mac_v <= 1'b0;
            r_ov <= 1'b0; r_pv <= 1'b0; r_usr <= '0; r_last <= 1'b0; r_rdv <= 1'b0;
            r_wait <= 1'b0;
        end else if ((r_st == ST_READ || r_st == ST_FLAG) && !r_wait && r_rdv) begin
            r_wait <= 1'b1; r_rdv <= 1'b0;
        end else begin
            r_wait <= 1'b0;
            r_st <= n_st; r_cnt <= n_cnt; r_lb <= n_lb; r_i <= n_i; r_j <= n_j;
            r_k <= n_k; r_eq <= n_eq; r_acc <= n_acc;
            r_mac_v <= n_mac_v; r_ov <= n_ov; r_pv <= n_pv; r_usr <= n_usr;
            r_last <= n_last;
            r_rdv <= (n_st == ST_READ) && (r_st == ST_READ) ? 1'b1 : n_rdv;
        end
    end
    always_ff @(posedge i_clk) begin
        if (r_st != ST_EMIT) r_val <= n_val;
    end

    assign m_axis_tvalid = (r_st == ST_EMIT);
    assign m_axis_tdata  = r_val;
    assign m_axis_tuser  = r_usr;
    assign m_axis_tlast  = r_last;

    // Checks
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_LOAD) |-> !s_axis_tready) else $error("input taken while busy");
    a_flag_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != 2'b00) |-> m_axis_tlast)
        else $error("flag item not last");
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(r_val))
        else $error("result dropped");
endmodule

// ===== test/testbench.sv =====
// Testbench for the small matrix arithmetic unit: directed and random matrix runs.
`timescale 1ns / 1ps
module testbench;
    import smau_pkg::*;

    typedef struct {
        logic [39:0] value;
        logic        equal_flag;
        logic        dim_error;
        logic        is_last;
    } t_result;

    // Expected results of the matrix unit, checked in arrival order
    class matrix_scoreboard;
        logic [2:0]  op_mode;
        logic [3:0]  dims [4];
        logic signed [15:0] a_mem [64];
        logic signed [15:0] b_mem [64];
        int          load_count;
        bit          loading_b;
        t_result     pending [$];
        int          errors;

        function new();
            op_mode    = 3'd0;
            dims       = '{4'd1, 4'd1, 4'd1, 4'd1};
            load_count = 0;
            loading_b  = 0;
            errors     = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [3:0] data);
            if (idx == REG_OP_MODE) op_mode = data[2:0];
            else if (idx <= REG_COLS_B) dims[idx - 1] = data;
        endfunction

        function int clamp(logic [3:0] d);
            if (d == 0) return 1;
            if (d > 8) return 8;
            return d;
        endfunction

        function logic [39:0] sat40(longint v);
            if (v > 64'sd549755813887) return 40'h7F_FFFF_FFFF;
            if (v < -64'sd549755813888) return 40'h80_0000_0000;
            return v[39:0];
        endfunction

        function void push(logic [39:0] v, bit eq, bit err, bit last);
            t_result r;
            r.value = v; r.equal_flag = eq; r.dim_error = err; r.is_last = last;
            pending.push_back(r);
        endfunction

        // Note an accepted element and predict its results
        function void note_element(logic signed [15:0] e);
            int ra, ca, rb, cb;
            longint acc, p;
            bit eq;
            ra = clamp(dims[0]); ca = clamp(dims[1]);
            rb = clamp(dims[2]); cb = clamp(dims[3]);
            if (!loading_b) begin
                if (load_count < 64) a_mem[load_count] = e;
                if (load_count + 1 < ra * ca) begin
                    load_count++;
                    return;
                end
                load_count = 0;
                if (op_mode != OP_TRN) begin
                    loading_b = 1;
                    return;
                end
                for (int i = 0; i < ca; i++)
                    for (int j = 0; j < ra; j++)
                        push(sat40(longint'(a_mem[j*ca+i]) <<< 8), 0, 0,
                             i + 1 == ca && j + 1 == ra);
                return;
            end
            if (load_count < 64) b_mem[load_count] = e;
            if (load_count + 1 < rb * cb) begin
                load_count++;
                return;
            end
            load_count = 0;
            loading_b  = 0;
            if (op_mode == OP_MUL && ca == rb) begin
                for (int i = 0; i < ra; i++)
                    for (int j = 0; j < cb; j++) begin
                        acc = 0;
                        for (int k = 0; k < ca; k++) begin
                            p = longint'(a_mem[i*ca+k]) * longint'(b_mem[k*cb+j]);
                            acc += p;
                        end
                        push(sat40(acc), 0, 0, i + 1 == ra && j + 1 == cb);
                    end
            end else if ((op_mode == OP_ADD || op_mode == OP_SUB) && ra == rb && ca == cb)
            begin
                for (int i = 0; i < ra * ca; i++) begin
                    p = op_mode == OP_ADD ? longint'(a_mem[i]) + b_mem[i]
                                          : longint'(a_mem[i]) - b_mem[i];
                    push(sat40(p <<< 8), 0, 0, i + 1 == ra * ca);
                end
            end else if (op_mode == OP_EQ) begin
                eq = ra == rb && ca == cb;
                if (eq)
                    for (int i = 0; i < ra * ca; i++)
                        if (a_mem[i] != b_mem[i]) eq = 0;
                push('0, eq, 0, 1);
            end else begin
                push('0, 0, 1, 1);
            end
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                $error("unexpected result value=%h", got.value);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.value !== want.value) begin
                $error("value: expected %h actual %h", want.value, got.value);
                errors++;
            end
            if (got.equal_flag !== want.equal_flag) begin
                $error("equal_flag: expected %b actual %b", want.equal_flag, got.equal_flag);
                errors++;
            end
            if (got.dim_error !== want.dim_error) begin
                $error("dim_error: expected %b actual %b", want.dim_error, got.dim_error);
                errors++;
            end
            if (got.is_last !== want.is_last) begin
                $error("is_last: expected %b actual %b", want.is_last, got.is_last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_valid = 0;
    logic [2:0]  i_cfg_index = '0;
    logic [3:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 0;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tready = 0;
    logic        o_cfg_ready, s_axis_tready, m_axis_tvalid, m_axis_tlast;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    matrix_scoreboard board = new();
    int  send_idle = 0;
    int  recv_stall = 0;
    int  sent = 0;

    small_matrix_arithmetic_unit_core dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Receiver: random stall, check each result transaction
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.value = m_axis_tdata;
            got.equal_flag = m_axis_tuser[0];
            got.dim_error = m_axis_tuser[1];
            got.is_last = m_axis_tlast;
            board.check_result(got);
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    // Hold valid after the write; the caller drops it once the last one is taken
    task automatic write_reg(logic [2:0] idx, logic [3:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
    endtask

    // Hold valid after the transaction; idle cycles or the caller drop it
    task automatic send_element(logic [15:0] e);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= e;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_element(e);
        sent++;
    endtask

    // Wait for every expected result, then let the block settle
    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (700) @(posedge i_clk);
    endtask

    task automatic configure(logic [2:0] op, logic [3:0] ra, logic [3:0] ca,
                             logic [3:0] rb, logic [3:0] cb);
        drain();
        write_reg(REG_OP_MODE, {1'b0, op});
        write_reg(REG_ROWS_A, ra);
        write_reg(REG_COLS_A, ca);
        write_reg(REG_ROWS_B, rb);
        write_reg(REG_COLS_B, cb);
        i_cfg_valid <= 0;
    endtask

    function automatic int eff(logic [3:0] d);
        return d == 0 ? 1 : (d > 8 ? 8 : d);
    endfunction

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(($urandom_range(1) << 8) - 128);
            default: return 16'($urandom);
        endcase
    endfunction

    // One complete run; B is skipped in transpose mode
    task automatic run_matrices(logic [2:0] op, logic [3:0] ra, logic [3:0] ca,
                                logic [3:0] rb, logic [3:0] cb, bit copy_a);
        logic [15:0] a_copy [64];
        int na, nb;
        configure(op, ra, ca, rb, cb);
        na = eff(ra) * eff(ca);
        nb = eff(rb) * eff(cb);
        for (int i = 0; i < na; i++) begin
            a_copy[i] = rand_elem();
            send_element(a_copy[i]);
        end
        if (op != OP_TRN)
            for (int i = 0; i < nb; i++)
                send_element(copy_a && i < na ? a_copy[i] : rand_elem());
        s_axis_tvalid <= 0;
    endtask

    task automatic set_idling(int phase);
        case (phase % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 87; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 87; end
            default: begin send_idle = 29; recv_stall = 29; end
        endcase
    endtask

    initial begin
        logic [3:0] ra, ca, cb;
        logic [2:0] op;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Directed runs: every mode, extreme sizes, mismatches, odd dimensions
        run_matrices(OP_MUL, 1, 1, 1, 1, 0);
        run_matrices(OP_ADD, 1, 2, 1, 2, 0);
        run_matrices(OP_SUB, 2, 1, 2, 1, 0);
        run_matrices(OP_EQ,  2, 2, 2, 2, 1);
        run_matrices(OP_EQ,  2, 2, 2, 2, 0);
        run_matrices(OP_EQ,  1, 2, 2, 1, 0);
        run_matrices(OP_TRN, 2, 3, 1, 1, 0);
        run_matrices(OP_MUL, 1, 2, 3, 1, 0);
        run_matrices(OP_ADD, 1, 2, 2, 1, 0);
        run_matrices(3'd5, 1, 1, 1, 1, 0);
        run_matrices(3'd7, 1, 2, 1, 1, 0);
        run_matrices(OP_MUL, 0, 9, 15, 1, 0);
        run_matrices(OP_MUL, 1, 8, 8, 1, 0);
        // Random runs, mostly well-formed
        for (int phase = 0; sent < 320; phase++) begin
            set_idling(phase / 3);
            op = $urandom_range(99) < 90 ? 3'($urandom_range(4)) : 3'($urandom_range(7));
            ra = $urandom_range(15) == 0 ? 4'($urandom) : 4'($urandom_range(1, 3));
            ca = $urandom_range(15) == 0 ? 4'($urandom) : 4'($urandom_range(1, 3));
            cb = 4'($urandom_range(1, 3));
            if ($urandom_range(9) == 0)
                run_matrices(op, ra, ca, 4'($urandom_range(1, 3)), cb, 0);
            else if (op == OP_MUL)
                run_matrices(op, ra, ca, ca, cb, 0);
            else
                run_matrices(op, ra, ca, ra, ca, op == OP_EQ && $urandom_range(1));
        end
        set_idling(0);
        run_matrices(OP_MUL, 8, 8, 8, 8, 0);
        drain();
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
